[hdl/rotation_angle_tween_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the rotation angle tween
// Concurrent check macros on clk with rst_n low as the disable condition;
// they expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ROTATION_ANGLE_TWEEN_ASSERT_SVH
`define ROTATION_ANGLE_TWEEN_ASSERT_SVH
`ifndef SYNTHESIS
`define RAT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rotation_angle_tween: same-cycle check failed");
`define RAT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rotation_angle_tween: next-cycle check failed");
`else
`define RAT_ASSERT_IMP(label, ante, cons)
`define RAT_ASSERT_NXT(label, ante, cons)
`endif
`endif

[hdl/rat_pkg.sv]
// ---------------------------------------------------------------------------
// rat_pkg
// Types, constants and the arctangent table shared by the tween pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package rat_pkg;

  // event kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_STEP  = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // register indexes
  localparam logic [1:0] REG_ANGLE_START = 2'd0;
  localparam logic [1:0] REG_ANGLE_END   = 2'd1;
  localparam logic [1:0] REG_DURATION    = 2'd2;
  localparam int         CFG_ADDR_W      = 4;

  // time and ratio
  localparam int          TIME_W     = 52;
  localparam logic [19:0] USEC_PER_S = 20'd1000000;
  localparam int          REM_W      = 34;
  localparam int          RATIO_W    = 18;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 18'h3FFFF;
  localparam logic [RATIO_W-1:0] RATIO_ONE = 18'h10000;
  localparam int DIV_STEPS     = RATIO_W;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;

  // range reduction, Q32
  localparam int ANG_W  = 36;
  localparam int V_W    = 53;
  localparam int VH_W   = 33;
  localparam int M_W    = 60;
  localparam int KE_W   = 20;
  localparam int KT_W   = 56;
  localparam int RECIP_SHIFT = 40;
  localparam logic signed [26:0]     RECIP_2PI  = 27'sd42722830;
  localparam logic signed [KT_W-1:0] TWOPI_Q32  = 56'sd26986075409;
  localparam logic signed [KT_W-1:0] PI_Q32     = 56'sd13493037705;
  localparam logic signed [KT_W-1:0] HALFPI_Q32 = 56'sd6746518852;

  // CORDIC, Q30
  localparam int CW               = 34;
  localparam int ATAN_LEN         = 30;
  localparam int CORDIC_ITERS_DEF = 16;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] Q14_MAX  = 34'sd16384;

  typedef struct packed {
    logic signed [31:0] angle_start;
    logic signed [31:0] angle_end;
    logic        [31:0] duration_usec;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_sec;
    logic [19:0] now_usec;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] cos_term;
    logic signed [15:0] sin_term;
    logic               ratio_saturated;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [TIME_W-1:0] now_time;
  } time_item_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         kind;
    logic               sat;
    logic [REM_W-1:0]   rem;
    logic [RATIO_W-1:0] quo;
  } div_item_t;

  typedef struct packed {
    logic               valid;
    logic               sat;
    logic [RATIO_W-1:0] ratio;
  } ratio_item_t;

  typedef struct packed {
    logic               valid;
    logic               sat;
    logic               flip;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_item_t;

  // arctangent of 2^-idx in Q30
  function automatic logic signed [CW-1:0] atan_q30(input int unsigned idx);
    logic signed [CW-1:0] a;
    case (idx)
      0:  a = 34'sd843314857;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043837;
      3:  a = 34'sd133525159;
      4:  a = 34'sd67021687;
      5:  a = 34'sd33543516;
      6:  a = 34'sd16775851;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194283;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048576;
      11: a = 34'sd524288;
      12: a = 34'sd262144;
      13: a = 34'sd131072;
      14: a = 34'sd65536;
      15: a = 34'sd32768;
      16: a = 34'sd16384;
      17: a = 34'sd8192;
      18: a = 34'sd4096;
      19: a = 34'sd2048;
      20: a = 34'sd1024;
      21: a = 34'sd512;
      22: a = 34'sd256;
      23: a = 34'sd128;
      24: a = 34'sd64;
      25: a = 34'sd32;
      26: a = 34'sd16;
      27: a = 34'sd8;
      28: a = 34'sd4;
      29: a = 34'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[hdl/rotation_angle_tween.sv]
// ---------------------------------------------------------------------------
// rotation_angle_tween
// Rotation tween: one event item in, one (cos, sin, saturated) item out for
// each start, step or stop event; kind 3 is dropped without a result. The
// block takes one item per clock while in_stall is low; each item passes
// through two time stages, nine divider stages at two quotient bits each,
// five angle and range-reduction stages, one stage per CORDIC iteration
// and the output register. The whole pipeline advances as
// one; a stalled result holds every stage and raises in_stall. The rotation
// matrix is (cos, -sin, sin, cos). Registers are written over the APB port
// and must be changed only while no item is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rotation_angle_tween_assert.svh"

module rotation_angle_tween #(
  parameter int CORDIC_ITERS = rat_pkg::CORDIC_ITERS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  rat_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  wire                             out_stall,
  output rat_pkg::out_item_t              out_data,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [rat_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire [31:0]                      pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  rat_pkg::cfg_t          cfg_r;
  logic                   adv;
  logic                   take;
  rat_pkg::div_item_t     front_q;
  rat_pkg::ratio_item_t   ratio_q;
  rat_pkg::cordic_item_t  reduce_q;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        rat_pkg::REG_ANGLE_START: cfg_r.angle_start   <= pwdata;
        rat_pkg::REG_ANGLE_END:   cfg_r.angle_end     <= pwdata;
        rat_pkg::REG_DURATION:    cfg_r.duration_usec <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      rat_pkg::REG_ANGLE_START: prdata = cfg_r.angle_start;
      rat_pkg::REG_ANGLE_END:   prdata = cfg_r.angle_end;
      rat_pkg::REG_DURATION:    prdata = cfg_r.duration_usec;
      default:                  prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // advance the whole pipeline unless a result waits
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign take     = in_valid && (in_data.kind != rat_pkg::KIND_NONE);

  rat_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .cfg        (cfg_r),
    .item_valid (take),
    .item       (in_data),
    .div_out    (front_q)
  );

  rat_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .cfg       (cfg_r),
    .div_in    (front_q),
    .ratio_out (ratio_q)
  );

  rat_reduce u_reduce (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .cfg        (cfg_r),
    .ratio_in   (ratio_q),
    .cordic_out (reduce_q)
  );

  rat_cordic #(
    .ITERS (CORDIC_ITERS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .cordic_in (reduce_q),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // each result term stays within plus or minus one after clamping
  `RAT_ASSERT_IMP(a_cos_range, out_valid, (out_data.cos_term <= 16'sd16384) && (out_data.cos_term >= -16'sd16384))
  `RAT_ASSERT_IMP(a_sin_range, out_valid, (out_data.sin_term <= 16'sd16384) && (out_data.sin_term >= -16'sd16384))
  // a new result appears only after the pipeline advanced
  `RAT_ASSERT_IMP(a_out_after_adv, $rose(out_valid), $past(!in_stall))
  // a held result keeps the input side stalled in the next cycle while out_stall stays high
  `RAT_ASSERT_NXT(a_hold_stall, out_valid && out_stall, in_stall || !out_stall)

endmodule

`default_nettype wire

[hdl/rat_front.sv]
// ---------------------------------------------------------------------------
// rat_front
// Time front end: forms the microsecond timestamp, latches the start time
// and prepares the elapsed time for the ratio divider.
// ---------------------------------------------------------------------------
`default_nettype none

module rat_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  adv,
  input  rat_pkg::cfg_t        cfg,
  input  wire                  item_valid,
  input  rat_pkg::in_item_t    item,
  output rat_pkg::div_item_t   div_out
);

  rat_pkg::time_item_t           tm_r, tm_nxt;
  rat_pkg::div_item_t            dv_r, dv_nxt;
  logic [rat_pkg::TIME_W-1:0]    start_r, start_nxt;
  logic [rat_pkg::TIME_W-1:0]    diff;

  // timestamp: seconds times one million plus microseconds, mod 2^52
  always_comb begin
    tm_nxt.valid    = item_valid;
    tm_nxt.kind     = item.kind;
    tm_nxt.now_time = rat_pkg::TIME_W'(item.now_sec) * rat_pkg::TIME_W'(rat_pkg::USEC_PER_S)
                    + rat_pkg::TIME_W'(item.now_usec);
  end

  // elapsed time and saturation test
  always_comb begin
    diff          = tm_r.now_time - start_r;
    dv_nxt.valid  = tm_r.valid;
    dv_nxt.kind   = tm_r.kind;
    dv_nxt.sat    = (cfg.duration_usec == 32'd0) ||
                    (diff >= {18'd0, cfg.duration_usec, 2'b00});
    dv_nxt.rem    = diff[rat_pkg::REM_W-1:0];
    dv_nxt.quo    = '0;
    start_nxt     = start_r;
    if (tm_r.valid && (tm_r.kind == rat_pkg::KIND_START)) begin
      start_nxt = tm_r.now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tm_r.valid <= 1'b0;
      dv_r.valid <= 1'b0;
      start_r    <= '0;
    end else if (adv) begin
      tm_r    <= tm_nxt;
      dv_r    <= dv_nxt;
      start_r <= start_nxt;
    end
  end

  assign div_out = dv_r;

endmodule

`default_nettype wire

[hdl/rat_div.sv]
// ---------------------------------------------------------------------------
// rat_div
// Pipelined restoring divider: elapsed time * 2^16 / duration, two
// quotient bits per stage, then the ratio select by event kind.
// ---------------------------------------------------------------------------
`default_nettype none

module rat_div (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   adv,
  input  rat_pkg::cfg_t         cfg,
  input  rat_pkg::div_item_t    div_in,
  output rat_pkg::ratio_item_t  ratio_out
);

  localparam int N = rat_pkg::DIV_STAGES;

  rat_pkg::div_item_t        div_r   [N];
  rat_pkg::div_item_t        div_nxt [N];
  rat_pkg::div_item_t        div_src [N];
  logic [rat_pkg::REM_W-1:0] d2;
  rat_pkg::div_item_t        last;

  // divisor doubled, so the first compare yields quotient bit 17
  assign d2 = {1'b0, cfg.duration_usec, 1'b0};

  for (genvar gs = 0; gs < N; gs++) begin : g_stage
    if (gs == 0) begin : g_first
      assign div_src[gs] = div_in;
    end else begin : g_next
      assign div_src[gs] = div_r[gs-1];
    end

    // compare, subtract, shift in a quotient bit, double the remainder
    always_comb begin
      logic [rat_pkg::REM_W-1:0]   rem;
      logic [rat_pkg::RATIO_W-1:0] quo;
      rem = div_src[gs].rem;
      quo = div_src[gs].quo;
      for (int j = 0; j < rat_pkg::DIV_PER_STAGE; j++) begin
        if (rem >= d2) begin
          rem = rem - d2;
          quo = {quo[rat_pkg::RATIO_W-2:0], 1'b1};
        end else begin
          quo = {quo[rat_pkg::RATIO_W-2:0], 1'b0};
        end
        rem = {rem[rat_pkg::REM_W-2:0], 1'b0};
      end
      div_nxt[gs]     = div_src[gs];
      div_nxt[gs].rem = rem;
      div_nxt[gs].quo = quo;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_r[gs].valid <= 1'b0;
      end else if (adv) begin
        div_r[gs] <= div_nxt[gs];
      end
    end
  end

  assign last = div_r[N-1];

  // start takes ratio zero, stop ratio one, step the quotient or the limit
  always_comb begin
    ratio_out.valid = last.valid;
    case (last.kind)
      rat_pkg::KIND_START: begin
        ratio_out.ratio = '0;
        ratio_out.sat   = 1'b0;
      end
      rat_pkg::KIND_STOP: begin
        ratio_out.ratio = rat_pkg::RATIO_ONE;
        ratio_out.sat   = 1'b0;
      end
      default: begin
        ratio_out.ratio = last.sat ? rat_pkg::RATIO_MAX : last.quo;
        ratio_out.sat   = last.sat;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/rat_reduce.sv]
// ---------------------------------------------------------------------------
// rat_reduce
// Angle interpolation and range reduction into [-pi/2, pi/2] in five
// stages: scale, sum, reciprocal estimate, multiple of 2*pi, fold.
// ---------------------------------------------------------------------------
`default_nettype none

module rat_reduce (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    adv,
  input  rat_pkg::cfg_t          cfg,
  input  rat_pkg::ratio_item_t   ratio_in,
  output rat_pkg::cordic_item_t  cordic_out
);

  typedef struct packed {
    logic               valid;
    logic               sat;
    logic signed [51:0] prod;
  } s1_t;

  typedef struct packed {
    logic                            valid;
    logic                            sat;
    logic signed [rat_pkg::V_W-1:0]  v;
  } s2_t;

  typedef struct packed {
    logic                            valid;
    logic                            sat;
    logic signed [rat_pkg::V_W-1:0]  v;
    logic signed [rat_pkg::M_W-1:0]  m;
  } s3_t;

  typedef struct packed {
    logic                            valid;
    logic                            sat;
    logic signed [rat_pkg::V_W-1:0]  v;
    logic signed [rat_pkg::KT_W-1:0] kt;
  } s4_t;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  rat_pkg::cordic_item_t s5_r, s5_nxt;

  logic signed [32:0]                  delta;
  logic signed [rat_pkg::RATIO_W:0]    ratio_s;
  logic signed [rat_pkg::ANG_W-1:0]    ang;
  logic signed [rat_pkg::VH_W-1:0]     vh;
  logic signed [rat_pkg::KE_W-1:0]     ke;
  logic signed [rat_pkg::KT_W-1:0]     w0, w1, rr;

  // scale the angle span by the ratio
  always_comb begin
    delta        = {cfg.angle_end[31], cfg.angle_end} - {cfg.angle_start[31], cfg.angle_start};
    ratio_s      = {1'b0, ratio_in.ratio};
    s1_nxt.valid = ratio_in.valid;
    s1_nxt.sat   = ratio_in.sat;
    s1_nxt.prod  = delta * ratio_s;
  end

  // add the start angle, move to Q32 and offset by pi
  always_comb begin
    ang          = {{4{cfg.angle_start[31]}}, cfg.angle_start} + s1_r.prod[51:16];
    s2_nxt.valid = s1_r.valid;
    s2_nxt.sat   = s1_r.sat;
    s2_nxt.v     = {ang[rat_pkg::ANG_W-1], ang, 16'd0} + rat_pkg::PI_Q32[rat_pkg::V_W-1:0];
  end

  // estimate the turn count with a reciprocal of 2*pi
  always_comb begin
    vh           = s2_r.v[rat_pkg::V_W-1:20];
    s3_nxt.valid = s2_r.valid;
    s3_nxt.sat   = s2_r.sat;
    s3_nxt.v     = s2_r.v;
    s3_nxt.m     = vh * rat_pkg::RECIP_2PI;
  end

  // whole turns in Q32
  always_comb begin
    ke           = s3_r.m[rat_pkg::M_W-1:rat_pkg::RECIP_SHIFT];
    s4_nxt.valid = s3_r.valid;
    s4_nxt.sat   = s3_r.sat;
    s4_nxt.v     = s3_r.v;
    s4_nxt.kt    = ke * rat_pkg::TWOPI_Q32;
  end

  // correct the estimate by one turn, drop the pi offset, fold to half pi
  always_comb begin
    w0 = {{(rat_pkg::KT_W-rat_pkg::V_W){s4_r.v[rat_pkg::V_W-1]}}, s4_r.v} - s4_r.kt;
    if (w0 >= rat_pkg::TWOPI_Q32) begin
      w1 = w0 - rat_pkg::TWOPI_Q32;
    end else if (w0 < 0) begin
      w1 = w0 + rat_pkg::TWOPI_Q32;
    end else begin
      w1 = w0;
    end
    rr          = w1 - rat_pkg::PI_Q32;
    s5_nxt.flip = 1'b0;
    if (rr > rat_pkg::HALFPI_Q32) begin
      rr          = rr - rat_pkg::PI_Q32;
      s5_nxt.flip = 1'b1;
    end else if (rr < -rat_pkg::HALFPI_Q32) begin
      rr          = rr + rat_pkg::PI_Q32;
      s5_nxt.flip = 1'b1;
    end
    s5_nxt.valid = s4_r.valid;
    s5_nxt.sat   = s4_r.sat;
    s5_nxt.x     = rat_pkg::GAIN_Q30;
    s5_nxt.y     = '0;
    s5_nxt.z     = rr[rat_pkg::CW+1:2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      s4_r.valid <= 1'b0;
      s5_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
    end
  end

  assign cordic_out = s5_r;

endmodule

`default_nettype wire

[hdl/rat_cordic.sv]
// ---------------------------------------------------------------------------
// rat_cordic
// Rotation-mode CORDIC, one iteration per stage, followed by rounding to
// Q1.14 with clamp and the sign fold in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rat_cordic #(
  parameter int ITERS = rat_pkg::CORDIC_ITERS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    adv,
  input  rat_pkg::cordic_item_t  cordic_in,
  output logic                   out_valid,
  output rat_pkg::out_item_t     out_data
);

  rat_pkg::cordic_item_t c_r   [ITERS];
  rat_pkg::cordic_item_t c_nxt [ITERS];
  rat_pkg::cordic_item_t c_src [ITERS];
  rat_pkg::cordic_item_t last;

  logic                         out_valid_r;
  rat_pkg::out_item_t           out_r, out_nxt;
  logic signed [rat_pkg::CW-1:0] xr, yr;

  for (genvar gi = 0; gi < ITERS; gi++) begin : g_iter
    if (gi == 0) begin : g_first
      assign c_src[gi] = cordic_in;
    end else begin : g_next
      assign c_src[gi] = c_r[gi-1];
    end

    // rotate toward zero residual angle
    always_comb begin
      logic signed [rat_pkg::CW-1:0] dx, dy;
      dx        = c_src[gi].y >>> gi;
      dy        = c_src[gi].x >>> gi;
      c_nxt[gi] = c_src[gi];
      if (c_src[gi].z >= 0) begin
        c_nxt[gi].x = c_src[gi].x - dx;
        c_nxt[gi].y = c_src[gi].y + dy;
        c_nxt[gi].z = c_src[gi].z - rat_pkg::atan_q30(gi);
      end else begin
        c_nxt[gi].x = c_src[gi].x + dx;
        c_nxt[gi].y = c_src[gi].y - dy;
        c_nxt[gi].z = c_src[gi].z + rat_pkg::atan_q30(gi);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_r[gi].valid <= 1'b0;
      end else if (adv) begin
        c_r[gi] <= c_nxt[gi];
      end
    end
  end

  assign last = c_r[ITERS-1];

  // round Q30 to Q14, clamp, negate when folded
  always_comb begin
    xr = (last.x + rat_pkg::CW'(32768)) >>> 16;
    yr = (last.y + rat_pkg::CW'(32768)) >>> 16;
    if (xr > rat_pkg::Q14_MAX)  xr = rat_pkg::Q14_MAX;
    if (xr < -rat_pkg::Q14_MAX) xr = -rat_pkg::Q14_MAX;
    if (yr > rat_pkg::Q14_MAX)  yr = rat_pkg::Q14_MAX;
    if (yr < -rat_pkg::Q14_MAX) yr = -rat_pkg::Q14_MAX;
    if (last.flip) begin
      xr = -xr;
      yr = -yr;
    end
    out_nxt.cos_term        = xr[15:0];
    out_nxt.sin_term        = yr[15:0];
    out_nxt.ratio_saturated = last.sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.valid;
      out_r       <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[tb/tb_rotation_angle_tween.sv]
// ---------------------------------------------------------------------------
// Rotation angle tween testbench
// Writes the angle and duration registers over APB while the block is idle.
// Drives a directed table of event items, then random start/step/stop
// sequences with random idling on both channels. Every result is checked
// against a local model of the time ratio, angle blend and CORDIC.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rotation_angle_tween;

  localparam int  ITERS       = 16;
  localparam int  PIPE_DEPTH  = 17 + ITERS;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam longint TMASK    = (64'd1 << 52) - 1;
  localparam int  N_DIRECTED  = 15;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] sec;
    logic [19:0] usec;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  rat_pkg::in_item_t  in_data;
  rat_pkg::out_item_t out_data;
  logic psel, penable, pwrite, pready;
  logic [rat_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  // local copy of the registers and the latched start time
  logic [31:0] m_angle_start, m_angle_end, m_duration;
  longint unsigned m_start_time;

  rat_pkg::out_item_t pending_results[$];
  int  errors;
  int  cycles;
  bit  quiet;
  int  out_burst;

  longint atan_tab[ITERS] = '{843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
    524288, 262144, 131072, 65536, 32768};

  stim_row_t directed[N_DIRECTED] = '{
    '{rat_pkg::KIND_STEP,  32'd5,          20'd0},
    '{rat_pkg::KIND_START, 32'd0,          20'd0},
    '{rat_pkg::KIND_STEP,  32'd0,          20'd1},
    '{rat_pkg::KIND_STOP,  32'd0,          20'd0},
    '{rat_pkg::KIND_NONE,  32'hFFFFFFFF,   20'hFFFFF},
    '{rat_pkg::KIND_START, 32'hFFFFFFFF,   20'hFFFFF},
    '{rat_pkg::KIND_STEP,  32'hFFFFFFFF,   20'hFFFFF},
    '{rat_pkg::KIND_STEP,  32'd0,          20'd0},
    '{rat_pkg::KIND_STEP,  32'h00000001,   20'd999999},
    '{rat_pkg::KIND_STOP,  32'hFFFFFFFF,   20'd999999},
    '{rat_pkg::KIND_START, 32'd100,        20'd500000},
    '{rat_pkg::KIND_STEP,  32'd100,        20'd500001},
    '{rat_pkg::KIND_STEP,  32'd101,        20'd0},
    '{rat_pkg::KIND_STEP,  32'd99,         20'd0},
    '{rat_pkg::KIND_STOP,  32'd100,        20'd0}
  };

  rotation_angle_tween i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q30 to Q14 with rounding and clamp
  function automatic longint round_q14(longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  // range-reduced rotation-mode CORDIC of a Q15.16 angle
  function automatic void rotate_unit(input longint ang, output rat_pkg::out_item_t res);
    longint a, n, k, r, x, y, z, dx, dy, tp;
    bit flip;
    tp = longint'(rat_pkg::TWOPI_Q32);
    a = ang * 65536;
    n = a + longint'(rat_pkg::PI_Q32);
    k = (n >= 0) ? n / tp : -((-n + tp - 1) / tp);
    r = a - k * tp;
    flip = 1'b0;
    if (r > longint'(rat_pkg::HALFPI_Q32)) begin
      r -= longint'(rat_pkg::PI_Q32);
      flip = 1'b1;
    end else if (r < -longint'(rat_pkg::HALFPI_Q32)) begin
      r += longint'(rat_pkg::PI_Q32);
      flip = 1'b1;
    end
    z = r >>> 2;
    x = longint'(rat_pkg::GAIN_Q30);
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    x = round_q14(x);
    y = round_q14(y);
    if (flip) begin
      x = -x; y = -y;
    end
    res.cos_term = x[15:0];
    res.sin_term = y[15:0];
    res.ratio_saturated = 1'b0;
  endfunction

  // work out the result of one accepted event item
  function automatic void predict_rotation(input rat_pkg::in_item_t it);
    longint unsigned now, diff, dur, ratio;
    longint a1, a2, ang;
    rat_pkg::out_item_t res;
    bit sat;
    a1 = longint'(signed'(m_angle_start));
    a2 = longint'(signed'(m_angle_end));
    now = (longint'(it.now_sec) * 1000000 + longint'(it.now_usec)) & TMASK;
    sat = 1'b0;
    case (it.kind)
      rat_pkg::KIND_START: begin
        m_start_time = now;
        rotate_unit(a1, res);
      end
      rat_pkg::KIND_STEP: begin
        diff = (now - m_start_time) & TMASK;
        dur = m_duration;
        if (dur == 0 || diff >= 4 * dur) begin
          ratio = rat_pkg::RATIO_MAX;
          sat = 1'b1;
        end else begin
          ratio = (diff << 16) / dur;
          if (ratio > rat_pkg::RATIO_MAX) begin
            ratio = rat_pkg::RATIO_MAX;
            sat = 1'b1;
          end
        end
        ang = a1 + (((a2 - a1) * longint'(ratio)) >>> 16);
        rotate_unit(ang, res);
        res.ratio_saturated = sat;
      end
      rat_pkg::KIND_STOP: rotate_unit(a2, res);
      default: return;
    endcase
    pending_results.push_back(res);
  endfunction

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin
    rat_pkg::out_item_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.cos_term !== want.cos_term) begin
          $display("%0t: cos_term expected %0d actual %0d", $time,
                   want.cos_term, out_data.cos_term);
          errors++;
        end
        if (out_data.sin_term !== want.sin_term) begin
          $display("%0t: sin_term expected %0d actual %0d", $time,
                   want.sin_term, out_data.sin_term);
          errors++;
        end
        if (out_data.ratio_saturated !== want.ratio_saturated) begin
          $display("%0t: ratio_saturated expected %0b actual %0b", $time,
                   want.ratio_saturated, out_data.ratio_saturated);
          errors++;
        end
      end
    end
  end

  // stall the result channel in random bursts
  always @(negedge clk) begin
    if (out_burst > 0) begin
      out_burst <= out_burst - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_burst <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // end the run on a hung pipeline
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= rat_pkg::CFG_ADDR_W'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      rat_pkg::REG_ANGLE_START: m_angle_start = val;
      rat_pkg::REG_ANGLE_END:   m_angle_end = val;
      default:                  m_duration = val;
    endcase
  endtask

  // drop the input, then wait for the pipeline to drain, including dropped items
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] a1, input logic [31:0] a2,
                            input logic [31:0] dur);
    drain();
    cfg_write(rat_pkg::REG_ANGLE_START, a1);
    cfg_write(rat_pkg::REG_ANGLE_END, a2);
    cfg_write(rat_pkg::REG_DURATION, dur);
  endtask

  // offer one item, with an optional idle burst ahead of it
  task automatic send_item(input logic [1:0] kind, input logic [31:0] sec,
                           input logic [19:0] usec);
    rat_pkg::in_item_t it;
    int gap;
    it.kind = kind; it.now_sec = sec; it.now_usec = usec;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_rotation(it);
  endtask

  task automatic send_time(input logic [1:0] kind, input longint unsigned t);
    logic [19:0] u;
    u = 20'(t % 1000000);
    if ($urandom_range(0, 30) == 0) u = 20'($urandom_range(0, 20'hFFFFF));
    send_item(kind, 32'(t / 1000000), u);
  endtask

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'd0;
      3: return $urandom;
      default: return 32'($signed($urandom_range(0, 1600000)) - 800000);
    endcase
  endfunction

  function automatic logic [31:0] pick_duration();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      2: return 32'd1;
      default: return $urandom_range(1, 5000000);
    endcase
  endfunction

  initial begin
    longint unsigned base, t;
    logic [31:0] dur;
    int sent, seq_len;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    m_angle_start = '0; m_angle_end = '0; m_duration = '0; m_start_time = 0;
    errors = 0; cycles = 0; quiet = 1'b0; out_burst = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table at reset registers, at two extreme settings, then from pi/2 to -pi/2
    foreach (directed[i]) send_item(directed[i].kind, directed[i].sec, directed[i].usec);
    set_config(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    foreach (directed[i]) send_item(directed[i].kind, directed[i].sec, directed[i].usec);
    set_config(32'h80000000, 32'h7FFFFFFF, 32'd1);
    foreach (directed[i]) send_item(directed[i].kind, directed[i].sec, directed[i].usec);
    set_config(32'h00019220, 32'hFFFE6DE0, 32'd2000000);
    foreach (directed[i]) send_item(directed[i].kind, directed[i].sec, directed[i].usec);

    // random phases: start, rising steps, stop, with some noise
    sent = 0;
    while (sent < 1950) begin
      if (sent >= 1700) quiet = 1'b1;
      dur = pick_duration();
      set_config(pick_angle(), pick_angle(), dur);
      repeat (6) begin
        base = {$urandom, $urandom} & TMASK;
        if ($urandom_range(0, 9) == 0) base = TMASK - $urandom_range(0, 1000);
        send_time(rat_pkg::KIND_START, base);
        seq_len = $urandom_range(4, 40);
        t = base;
        for (int j = 0; j < seq_len; j++) begin
          case ($urandom_range(0, 19))
            0: send_item(rat_pkg::KIND_NONE, $urandom, 20'($urandom));
            1: send_item(rat_pkg::KIND_STEP, $urandom, 20'($urandom));
            2: send_time(rat_pkg::KIND_STEP, (base - $urandom_range(1, 100000)) & TMASK);
            default: begin
              t = t + ((dur == 0 || dur > 10000000) ? $urandom :
                       $urandom_range(0, dur / 4 + 1));
              send_time(rat_pkg::KIND_STEP, t & TMASK);
            end
          endcase
        end
        send_time(rat_pkg::KIND_STOP, t & TMASK);
        sent += seq_len + 2;
      end
    end

    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
